// ----- rtl/warning_priority_arbiter_core_defines.svh -----
// Assertion macros of the warning priority arbiter checker.
// Included by the checker file; depends on nothing else.
`ifndef WARNING_PRIORITY_ARBITER_CORE_DEFINES_SVH
`define WARNING_PRIORITY_ARBITER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define WPA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge.
`define WPA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/wpa_pkg.sv -----
// Types, codes and the class comparison of the warning priority arbiter.
// Used by the arbiter core, the cell and the checker; depends on nothing.
`default_nettype none

package wpa_pkg;

  localparam int SLOTS = 16;
  localparam int SLOT_W = 4;
  localparam int CNT_W = $clog2(SLOTS + 1);

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_APPLY = 1'b1;

  localparam logic [2:0] CLS_A = 3'd1;
  localparam logic [2:0] CLS_B = 3'd2;
  localparam logic [2:0] CLS_C = 3'd3;
  localparam logic [2:0] CLS_D = 3'd4;
  localparam logic [2:0] CLS_OSD = 3'd5;

  localparam logic [1:0] MODE_ONE = 2'd1;
  localparam logic [1:0] MODE_TWO = 2'd2;

  localparam logic [2:0] ACT_HOLD = 3'd0;
  localparam logic [2:0] ACT_CLEAR = 3'd1;
  localparam logic [2:0] ACT_DROP = 3'd2;
  localparam logic [2:0] ACT_COMPACT = 3'd3;
  localparam logic [2:0] ACT_INSERT = 3'd4;
  localparam logic [2:0] ACT_ROTATE = 3'd5;

  typedef struct packed {
    logic              operation;
    logic [3:0]        entry_index;
    logic [2:0]        entry_class;
    logic [7:0]        entry_priority;
    logic [15:0]       entry_window;
    logic              entry_ack_allowed;
    logic [1:0]        entry_mode;
    logic [SLOTS-1:0]  active_mask;
  } wpa_req_t;

  typedef struct packed {
    logic        window_shown;
    logic [15:0] window_number;
    logic        ack_enabled;
    logic [3:0]  winner_slot;
  } wpa_res_t;

  typedef struct packed {
    logic [2:0]  cls;
    logic [7:0]  prio;
    logic [15:0] window;
    logic        ack;
    logic [1:0]  mode;
  } entry_t;

  typedef struct packed {
    logic              valid;
    logic [SLOT_W-1:0] slot;
  } cell_t;

  typedef struct packed {
    logic [2:0]        action;
    logic              insert;
    logic [SLOT_W-1:0] slot;
  } cell_ctl_t;

  function automatic logic is_interrupt(input logic [2:0] c);
    return (c == CLS_C) || (c == CLS_OSD);
  endfunction

  // True when candidate b replaces the current best a.
  function automatic logic b_wins(input entry_t a, input entry_t b);
    logic r;
    if (a.cls == b.cls) r = b.prio < a.prio;
    else if (is_interrupt(a.cls)) r = 1'b0;
    else if (is_interrupt(b.cls)) r = 1'b1;
    else if (a.cls == CLS_A) r = 1'b0;
    else if (b.cls == CLS_A) r = 1'b1;
    else if (a.cls == CLS_B) r = 1'b0;
    else if (b.cls == CLS_B) r = 1'b1;
    else if (a.cls == CLS_D) r = 1'b0;
    else r = 1'b1;
    return r;
  endfunction

  function automatic logic mode_admits(input logic [1:0] vmode, input logic [1:0] m);
    logic r;
    if (vmode == MODE_ONE) r = (m == MODE_ONE) || (m == MODE_TWO);
    else r = (m == MODE_TWO);
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/wpa_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; depends on nothing.
`default_nettype none

module wpa_ram #(
  parameter int WIDTH = 30,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/wpa_cell.sv -----
// One cell of the display queue chain: holds one queued slot number.
// Depends on wpa_pkg.
`default_nettype none

module wpa_cell import wpa_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  cell_ctl_t        ctl,
  input  logic [SLOTS-1:0] active,
  input  logic             prev_valid,
  input  logic             hole_in,
  input  cell_t            nxt,
  output cell_t            data,
  output logic             hole_out,
  output logic             match
);

  logic              valid;
  logic              valid_next;
  logic [SLOT_W-1:0] slot;
  logic [SLOT_W-1:0] slot_next;

  assign data = '{valid: valid, slot: slot};
  assign hole_out = hole_in | ~valid;
  assign match = valid && (slot == ctl.slot);

  always_comb begin
    valid_next = valid;
    slot_next = slot;
    unique case (ctl.action)
      ACT_CLEAR: valid_next = 1'b0;
      ACT_DROP: valid_next = valid & active[slot];
      ACT_COMPACT: begin
        if (hole_out) begin
          valid_next = nxt.valid;
          slot_next = nxt.slot;
        end
      end
      ACT_INSERT: begin
        if (ctl.insert && !valid && prev_valid) begin
          valid_next = 1'b1;
          slot_next = ctl.slot;
        end
      end
      ACT_ROTATE: begin
        valid_next = nxt.valid;
        slot_next = nxt.slot;
      end
      default: begin
        valid_next = valid;
        slot_next = slot;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    slot <= slot_next;
  end

endmodule

`default_nettype wire

// ----- rtl/warning_priority_arbiter_core.sv -----
// Warning priority arbiter: entry table, queue cell chain and winner fold.
// Depends on wpa_pkg, wpa_ram and wpa_cell.
//
//   channel   handshake               payload
//   request   start / busy            request   (wpa_req_t)
//   result    done (one-cycle strobe) result    (wpa_res_t)
//   config    cfg_valid / cfg_ready   cfg_data  (vehicle mode)
//
// A write request writes the table RAM and empties the queue at the
// accepting edge. An apply request keeps busy high while it drops inactive
// cells, compacts the chain, appends new slots in order, and rotates the
// chain past the RAM read port to fold the winner, then finishes. The done
// strobe follows in the next cycle. Reset empties the queue, clears the
// loaded bits and sets mode 1. The receiver cannot stall; configuration is
// accepted only while idle.
`default_nettype none

module warning_priority_arbiter_core import wpa_pkg::*; #(
  parameter int ENTRIES = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  wpa_req_t   request,
  output logic       done,
  output wpa_res_t   result,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_data
);

  localparam int CELLS = (ENTRIES < SLOTS) ? ENTRIES : SLOTS;
  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DROP = 3'd1;
  localparam logic [2:0] ST_COMPACT = 3'd2;
  localparam logic [2:0] ST_APPEND = 3'd3;
  localparam logic [2:0] ST_FOLD = 3'd4;
  localparam logic [2:0] ST_FINISH = 3'd5;

  logic [2:0]        state;
  logic [2:0]        state_next;
  logic [CNT_W-1:0]  cnt;
  logic [CNT_W-1:0]  cnt_next;
  logic [1:0]        vehicle_mode;
  logic [SLOTS-1:0]  loaded;
  logic [SLOTS-1:0]  active;
  logic              accept;
  logic              write_ok;
  logic              apply_go;
  entry_t            wr_entry;

  cell_ctl_t         ctl;
  cell_t             cells [CELLS];
  cell_t             nxt [CELLS];
  logic [CELLS-1:0]  prev_valid;
  logic [CELLS-1:0]  hole_in;
  logic [CELLS-1:0]  hole_out;
  logic [CELLS-1:0]  match;
  logic              present;

  entry_t            rdata;
  logic              p_valid;
  logic [SLOT_W-1:0] p_slot;
  logic              found;
  logic              found_next;
  entry_t            best;
  entry_t            best_next;
  logic [SLOT_W-1:0] best_slot;
  logic [SLOT_W-1:0] best_slot_next;
  logic              take;

  assign busy = (state != ST_IDLE);
  assign cfg_ready = ~busy;
  assign accept = start & ~busy;
  assign write_ok = accept && (request.operation == OP_WRITE) &&
                    (32'(request.entry_index) < ENTRIES);
  assign apply_go = accept && (request.operation == OP_APPLY);
  assign wr_entry = '{cls: request.entry_class, prio: request.entry_priority,
                      window: request.entry_window, ack: request.entry_ack_allowed,
                      mode: request.entry_mode};

  wpa_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(ENTRIES)
  ) u_table (
    .clk  (clk),
    .we   (write_ok),
    .waddr(AW'(request.entry_index)),
    .wdata(wr_entry),
    .re   (state == ST_FOLD),
    .raddr(AW'(cells[0].slot)),
    .rdata(rdata)
  );

  always_comb begin
    ctl = '{action: ACT_HOLD, insert: 1'b0, slot: cnt[SLOT_W-1:0]};
    if (write_ok) begin
      ctl.action = ACT_CLEAR;
    end else begin
      unique case (state)
        ST_DROP: ctl.action = ACT_DROP;
        ST_COMPACT: ctl.action = ACT_COMPACT;
        ST_APPEND: begin
          ctl.action = ACT_INSERT;
          ctl.insert = active[cnt[SLOT_W-1:0]] & ~present;
        end
        ST_FOLD: ctl.action = ACT_ROTATE;
        default: ctl.action = ACT_HOLD;
      endcase
    end
  end

  assign present = |match;

  for (genvar i = 0; i < CELLS; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign prev_valid[i] = 1'b1;
      assign hole_in[i] = 1'b0;
    end else begin : g_body
      assign prev_valid[i] = cells[i-1].valid;
      assign hole_in[i] = hole_out[i-1];
    end
    if (i == CELLS - 1) begin : g_tail
      assign nxt[i] = '{valid: (ctl.action == ACT_ROTATE) & cells[0].valid,
                        slot: cells[0].slot};
    end else begin : g_link
      assign nxt[i] = cells[i+1];
    end

    wpa_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .active    (active),
      .prev_valid(prev_valid[i]),
      .hole_in   (hole_in[i]),
      .nxt       (nxt[i]),
      .data      (cells[i]),
      .hole_out  (hole_out[i]),
      .match     (match[i])
    );
  end

  always_comb begin
    take = p_valid && mode_admits(vehicle_mode, rdata.mode) &&
           (!found || b_wins(best, rdata));
    found_next = found | take;
    best_next = take ? rdata : best;
    best_slot_next = take ? p_slot : best_slot;
  end

  always_comb begin
    state_next = state;
    cnt_next = cnt + CNT_W'(1);
    unique case (state)
      ST_IDLE: begin
        cnt_next = '0;
        if (apply_go) state_next = ST_DROP;
      end
      ST_DROP: begin
        cnt_next = '0;
        state_next = ST_COMPACT;
      end
      ST_COMPACT: begin
        if (cnt == CNT_W'(CELLS - 1)) begin
          cnt_next = '0;
          state_next = ST_APPEND;
        end
      end
      ST_APPEND: begin
        if (cnt == CNT_W'(SLOTS - 1)) begin
          cnt_next = '0;
          state_next = ST_FOLD;
        end
      end
      ST_FOLD: begin
        if (cnt == CNT_W'(CELLS - 1)) begin
          cnt_next = '0;
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt <= '0;
      vehicle_mode <= MODE_ONE;
      loaded <= '0;
      p_valid <= 1'b0;
      found <= 1'b0;
      done <= 1'b0;
    end else begin
      state <= state_next;
      cnt <= cnt_next;
      if (cfg_valid && cfg_ready) begin
        vehicle_mode <= cfg_data;
      end
      if (write_ok) begin
        loaded[request.entry_index] <= 1'b1;
      end
      p_valid <= (state == ST_FOLD) && cells[0].valid;
      found <= apply_go ? 1'b0 : found_next;
      done <= (state == ST_FINISH);
    end
  end

  always_ff @(posedge clk) begin
    if (apply_go) begin
      active <= request.active_mask & loaded;
    end
    p_slot <= cells[0].slot;
    best <= best_next;
    best_slot <= best_slot_next;
    if (state == ST_FINISH) begin
      result.window_shown <= found_next;
      result.window_number <= found_next ? best_next.window : '0;
      result.ack_enabled <= found_next && best_next.ack && (vehicle_mode == MODE_TWO);
      result.winner_slot <= found_next ? best_slot_next : '0;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/wpa_checker.sv -----
// Port-level checks of the warning priority arbiter, bound to the top level.
// Depends on wpa_pkg and warning_priority_arbiter_core_defines.svh.
`default_nettype none

`include "warning_priority_arbiter_core_defines.svh"

module wpa_checker import wpa_pkg::*; (
  input logic     clk,
  input logic     rst,
  input logic     start,
  input logic     busy,
  input wpa_req_t request,
  input logic     done,
  input wpa_res_t result
);

  `WPA_ASSERT_NOW(a_done_idle, clk, rst, done, !busy, "Result strobe while busy.")
  `WPA_ASSERT_NEXT(a_apply_busy, clk, rst, start && !busy && request.operation == OP_APPLY, busy && !done, "Apply request did not start work.")
  `WPA_ASSERT_NEXT(a_write_quick, clk, rst, start && !busy && request.operation == OP_WRITE, !busy && !done, "Write request held the block or gave a result.")
  `WPA_ASSERT_NOW(a_empty_zero, clk, rst, done && !result.window_shown, result.window_number == 16'd0 && result.winner_slot == 4'd0 && !result.ack_enabled, "Empty result carries nonzero fields.")

endmodule

bind warning_priority_arbiter_core wpa_checker u_wpa_checker (.*);

`default_nettype wire
